>>> src/laplacian_zero_crossing_edges_macros.svh
// Assertion macros shared by the edge detector RTL.
`ifndef LAPLACIAN_ZERO_CROSSING_EDGES_MACROS_SVH
`define LAPLACIAN_ZERO_CROSSING_EDGES_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define LZCE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LZCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/lzce_pkg.sv
// Shared constants, codes and types of the Laplacian zero-crossing edge detector.
`default_nettype none

package lzce_pkg;

    // Line length and derived widths
    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WID_W      = COL_W + 1;
    localparam int MIN_SIZE   = 3;
    localparam int MAX_HEIGHT = 1024;
    localparam int ROW_W      = 11;

    // Field widths
    localparam int RED_W     = 8;
    localparam int LAP_W     = RED_W + 3;
    localparam int THR_W     = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int PIX_ROW_W = 10;
    localparam int PIX_COL_W = 10;
    localparam int CMP_W     = (WID_W > CFG_W) ? WID_W : CFG_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST    = 11'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST   = 11'd480;
    localparam logic [THR_W-1:0] EDGE_THRESHOLD_RST = 8'd10;

    // Item codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_PAD   = 1'b1;

    // Result codes
    localparam logic [RED_W-1:0] EDGE_ON  = 8'hFF;
    localparam logic [RED_W-1:0] EDGE_OFF = 8'h00;

    // Control from the sequencer to the line stores
    typedef struct packed {
        logic                    adv;
        logic                    slot;
        logic                    wr_pix;
        logic [COL_W-1:0]        wr_col;
        logic [COL_W-1:0]        rd_col;
        logic [RED_W-1:0]        cur;
        logic signed [LAP_W-1:0] lap_new;
    } t_win_ctl;

    // Neighborhood around the current column
    typedef struct packed {
        logic [RED_W-1:0]        now_c;
        logic [RED_W-1:0]        now_r;
        logic [RED_W-1:0]        prev_l;
        logic [RED_W-1:0]        prev_c;
        logic [RED_W-1:0]        prev_r;
        logic signed [LAP_W-1:0] lap_c;
        logic signed [LAP_W-1:0] lap_r;
    } t_taps;

    // One result beat
    typedef struct packed {
        logic                 has_res;
        logic [RED_W-1:0]     edge_value;
        logic [PIX_ROW_W-1:0] pixel_row;
        logic [PIX_COL_W-1:0] pixel_col;
        logic                 frame_end;
    } t_result;

endpackage

`default_nettype wire

>>> src/lzce_window.sv
// Line memories for red samples and Laplacians, with the 3-column window registers.
`default_nettype none

module lzce_window (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lzce_pkg::t_win_ctl i_ctl,
    output lzce_pkg::t_taps   o_taps
);
    import lzce_pkg::*;

    // Red line memories, one per row parity, and the Laplacian line memory
    logic [RED_W-1:0]        r_pix_line0 [MAX_WIDTH];
    logic [RED_W-1:0]        r_pix_line1 [MAX_WIDTH];
    logic signed [LAP_W-1:0] r_lap_line  [MAX_WIDTH];

    // Read data: column ahead of the current one
    logic [RED_W-1:0]        r_q0;
    logic [RED_W-1:0]        r_q1;
    logic signed [LAP_W-1:0] r_lap_q;

    // Window: current and left columns per parity, current Laplacian
    logic [RED_W-1:0]        r_cen0;
    logic [RED_W-1:0]        r_cen1;
    logic [RED_W-1:0]        r_lft0;
    logic [RED_W-1:0]        r_lft1;
    logic signed [LAP_W-1:0] r_lap_c;

    // Write the current beat, fetch the column needed one beat later
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            if (i_ctl.wr_pix && !i_ctl.slot) begin
                r_pix_line0[i_ctl.wr_col] <= i_ctl.cur;
            end
            if (i_ctl.wr_pix && i_ctl.slot) begin
                r_pix_line1[i_ctl.wr_col] <= i_ctl.cur;
            end
            r_lap_line[i_ctl.wr_col] <= i_ctl.lap_new;
            r_q0    <= r_pix_line0[i_ctl.rd_col];
            r_q1    <= r_pix_line1[i_ctl.rd_col];
            r_lap_q <= r_lap_line[i_ctl.rd_col];
        end
    end

    // Shift the window one column per beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cen0  <= '0;
            r_cen1  <= '0;
            r_lft0  <= '0;
            r_lft1  <= '0;
            r_lap_c <= '0;
        end else if (i_ctl.adv) begin
            r_lft0  <= r_cen0;
            r_lft1  <= r_cen1;
            r_cen0  <= r_q0;
            r_cen1  <= r_q1;
            r_lap_c <= r_lap_q;
        end
    end

    // Map parity slots to two rows up and one row up
    always_comb begin
        if (i_ctl.slot) begin
            o_taps.now_c  = r_cen1;
            o_taps.now_r  = r_q1;
            o_taps.prev_l = r_lft0;
            o_taps.prev_c = r_cen0;
            o_taps.prev_r = r_q0;
        end else begin
            o_taps.now_c  = r_cen0;
            o_taps.now_r  = r_q0;
            o_taps.prev_l = r_lft1;
            o_taps.prev_c = r_cen1;
            o_taps.prev_r = r_q1;
        end
        o_taps.lap_c = r_lap_c;
        o_taps.lap_r = r_lap_q;
    end

endmodule

`default_nettype wire

>>> src/lzce_detect.sv
// Laplacian of the row above and zero-crossing test of the row two up.
`default_nettype none

module lzce_detect (
    input  logic [lzce_pkg::ROW_W-1:0] i_row,
    input  logic [lzce_pkg::COL_W-1:0] i_col,
    input  logic [lzce_pkg::WID_W-1:0] i_eff_w,
    input  logic [lzce_pkg::ROW_W-1:0] i_eff_h,
    input  logic [lzce_pkg::THR_W-1:0] i_thr,
    input  logic [lzce_pkg::RED_W-1:0] i_cur,
    input  lzce_pkg::t_taps            i_taps,
    output logic signed [lzce_pkg::LAP_W-1:0] o_lap_new,
    output lzce_pkg::t_result          o_res
);
    import lzce_pkg::*;

    // True when the two values have strictly opposite signs
    function automatic logic opposite(input logic signed [LAP_W-1:0] a,
                                      input logic signed [LAP_W-1:0] b);
        logic a_neg;
        logic a_pos;
        logic b_neg;
        logic b_pos;
        a_neg = a[LAP_W-1];
        a_pos = !a[LAP_W-1] && (a != '0);
        b_neg = b[LAP_W-1];
        b_pos = !b[LAP_W-1] && (b != '0);
        return (a_neg && b_pos) || (a_pos && b_neg);
    endfunction

    function automatic logic [RED_W-1:0] absdiff(input logic [RED_W-1:0] a,
                                                 input logic [RED_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    logic [WID_W-1:0]              c_ext;
    logic                          col_inner;
    logic                          lr_ok;
    logic                          lap_cond;
    logic                          edge_cond;
    logic [RED_W+1:0]              sum4;
    logic [RED_W+1:0]              cen4;
    logic signed [LAP_W-1:0]       lap_full;
    logic signed [LAP_W-1:0]       lap_new;
    logic signed [LAP_W-1:0]       lap_r;
    logic                          hit_r;
    logic                          hit_d;
    logic [ROW_W-1:0]              row_out;
    logic [COL_W+PIX_COL_W-1:0]    col_wide;

    // Position tests: interior column, rows with a Laplacian, rows with a result
    assign c_ext     = {1'b0, i_col};
    assign col_inner = (i_col != '0) && ((c_ext + WID_W'(2)) <= i_eff_w);
    assign lr_ok     = (c_ext + WID_W'(3)) <= i_eff_w;
    assign lap_cond  = (i_row >= ROW_W'(2)) && ((i_row + ROW_W'(1)) <= i_eff_h) && col_inner;
    assign edge_cond = (i_row >= ROW_W'(3)) && (i_row <= i_eff_h) && col_inner;

    // Four neighbors minus four times the center; border Laplacians are zero
    assign sum4     = {2'b00, i_taps.now_c} + {2'b00, i_cur}
                    + {2'b00, i_taps.prev_l} + {2'b00, i_taps.prev_r};
    assign cen4     = {i_taps.prev_c, 2'b00};
    assign lap_full = $signed({1'b0, sum4} - {1'b0, cen4});
    assign lap_new  = lap_cond ? lap_full : '0;
    assign o_lap_new = lap_new;

    // Zero crossing toward the right and the lower neighbor
    assign lap_r = lr_ok ? i_taps.lap_r : '0;
    assign hit_r = opposite(i_taps.lap_c, lap_r)
                && (absdiff(i_taps.now_c, i_taps.now_r) >= i_thr);
    assign hit_d = opposite(i_taps.lap_c, lap_new)
                && (absdiff(i_taps.now_c, i_taps.prev_c) >= i_thr);

    // Result beat for the pixel two rows up
    assign row_out  = i_row - ROW_W'(2);
    assign col_wide = {{PIX_COL_W{1'b0}}, i_col};

    always_comb begin
        o_res.has_res    = i_row >= ROW_W'(2);
        o_res.edge_value = (edge_cond && (hit_r || hit_d)) ? EDGE_ON : EDGE_OFF;
        o_res.pixel_row  = row_out[PIX_ROW_W-1:0];
        o_res.pixel_col  = col_wide[PIX_COL_W-1:0];
        o_res.frame_end  = (i_row == (i_eff_h + ROW_W'(1)))
                        && ((c_ext + WID_W'(1)) == i_eff_w);
    end

endmodule

`default_nettype wire

>>> src/laplacian_zero_crossing_edges.sv
// Top level of the streaming Laplacian zero-crossing edge detector.
// Takes one red sample per clock in raster order and returns one edge beat per
// item from input row 2 on, describing the pixel two rows up in the same column;
// after the frame the source sends 2*frame_width padding items to flush the last
// rows. An item is registered on entry and its result in the output register,
// so a pixel and a result move every clock while neither side stalls;
// the rate is set by the three line memories (two red rows by parity and one row
// of Laplacians, MAX_WIDTH entries each), each read once and written at most once per
// beat. The memories need no clearing pass: the block is ready right after reset.
// Border pixels always give 0. Write frame size and threshold only while idle.
`default_nettype none
`include "laplacian_zero_crossing_edges_macros.svh"

module laplacian_zero_crossing_edges (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration
    input  logic                           i_cfg_we,
    input  logic [lzce_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lzce_pkg::CFG_W-1:0]     i_cfg_data,
    // Pixel input
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_op,
    input  logic [lzce_pkg::RED_W-1:0]     i_red_value,
    // Edge output
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [lzce_pkg::RED_W-1:0]     o_edge_value,
    output logic [lzce_pkg::PIX_ROW_W-1:0] o_pixel_row,
    output logic [lzce_pkg::PIX_COL_W-1:0] o_pixel_col,
    output logic                           o_frame_end
);
    import lzce_pkg::*;

    // Configuration registers
    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic [THR_W-1:0] r_edge_threshold;

    // Input stage
    logic             r_s1_valid;
    logic             r_s1_op;
    logic [RED_W-1:0] r_s1_red;

    // Position of the item in the input stage
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] n_row;
    logic [COL_W-1:0] n_col;

    // Output stage
    logic                 r_out_valid;
    logic [RED_W-1:0]     r_out_edge;
    logic [PIX_ROW_W-1:0] r_out_row;
    logic [PIX_COL_W-1:0] r_out_col;
    logic                 r_out_end;

    logic [CMP_W-1:0]    w_cmp;
    logic [WID_W-1:0]    eff_w;
    logic [ROW_W-1:0]    eff_h;
    logic                real_row;
    logic [RED_W-1:0]    cur;
    logic [WID_W-1:0]    col_inc;
    logic [WID_W-1:0]    ncol_inc;
    logic                col_wrap;
    logic                frame_wrap;
    logic                out_free;
    logic                s1_adv;
    logic                in_acc;
    t_win_ctl            win_ctl;
    t_taps               taps;
    t_result             res;
    logic signed [LAP_W-1:0] lap_new;

    // Take register writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width    <= FRAME_WIDTH_RST;
            r_frame_height   <= FRAME_HEIGHT_RST;
            r_edge_threshold <= EDGE_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data;
                end
                CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data;
                end
                CFG_EDGE_THRESHOLD: begin
                    r_edge_threshold <= i_cfg_data[THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Clamp frame size to the supported range
    assign w_cmp = CMP_W'(r_frame_width);

    always_comb begin
        if (w_cmp < CMP_W'(MIN_SIZE)) begin
            eff_w = WID_W'(MIN_SIZE);
        end else if (w_cmp > CMP_W'(MAX_WIDTH)) begin
            eff_w = WID_W'(MAX_WIDTH);
        end else begin
            eff_w = WID_W'(w_cmp);
        end
        if (r_frame_height < ROW_W'(MIN_SIZE)) begin
            eff_h = ROW_W'(MIN_SIZE);
        end else if (r_frame_height > ROW_W'(MAX_HEIGHT)) begin
            eff_h = ROW_W'(MAX_HEIGHT);
        end else begin
            eff_h = r_frame_height;
        end
    end

    // Handshake: the input stage moves on when the output register has room or the item has no result
    assign out_free = !r_out_valid || !i_stall;
    assign s1_adv   = r_s1_valid && (!res.has_res || out_free);
    assign o_stall  = r_s1_valid && !s1_adv;
    assign in_acc   = i_valid && !o_stall;

    // Hold one input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op  <= i_op;
            r_s1_red <= i_red_value;
        end
    end

    // Padding and samples past the last real row count as red zero
    assign real_row = r_row < eff_h;
    assign cur      = (real_row && (r_s1_op == OP_PIXEL)) ? r_s1_red : '0;

    // Next raster position; wrap the frame after the two flush rows
    assign col_inc    = {1'b0, r_col} + WID_W'(1);
    assign col_wrap   = col_inc >= eff_w;
    assign frame_wrap = (r_row + ROW_W'(1)) >= (eff_h + ROW_W'(2));

    always_comb begin
        if (col_wrap) begin
            n_col = '0;
            n_row = frame_wrap ? '0 : (r_row + ROW_W'(1));
        end else begin
            n_col = col_inc[COL_W-1:0];
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (s1_adv) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // Fetch the column after the next position, wrapping to column zero
    assign ncol_inc = {1'b0, n_col} + WID_W'(1);

    always_comb begin
        win_ctl.adv     = s1_adv;
        win_ctl.slot    = r_row[0];
        win_ctl.wr_pix  = real_row;
        win_ctl.wr_col  = r_col;
        win_ctl.rd_col  = (ncol_inc >= eff_w) ? '0 : ncol_inc[COL_W-1:0];
        win_ctl.cur     = cur;
        win_ctl.lap_new = lap_new;
    end

    lzce_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (win_ctl),
        .o_taps  (taps)
    );

    lzce_detect u_detect (
        .i_row     (r_row),
        .i_col     (r_col),
        .i_eff_w   (eff_w),
        .i_eff_h   (eff_h),
        .i_thr     (r_edge_threshold),
        .i_cur     (cur),
        .i_taps    (taps),
        .o_lap_new (lap_new),
        .o_res     (res)
    );

    // Output register: load a result beat, hold it while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_adv && res.has_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && res.has_res) begin
            r_out_edge <= res.edge_value;
            r_out_row  <= res.pixel_row;
            r_out_col  <= res.pixel_col;
            r_out_end  <= res.frame_end;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_edge_value = r_out_edge;
    assign o_pixel_row  = r_out_row;
    assign o_pixel_col  = r_out_col;
    assign o_frame_end  = r_out_end;

    // A result never overwrites a beat still waiting downstream
    `LZCE_ASSERT_NOW(a_adv_room, i_clk, i_rst_n, s1_adv && res.has_res, out_free, "result advanced into a full output register")
    // An empty input stage never pushes back
    `LZCE_ASSERT_NOW(a_empty_no_stall, i_clk, i_rst_n, !r_s1_valid, !o_stall, "stall raised with empty input stage")
    // An accepted beat is held in the input stage
    `LZCE_ASSERT_NEXT(a_load, i_clk, i_rst_n, in_acc, r_s1_valid, "accepted beat lost")
    // Only the codes EDGE_ON and EDGE_OFF leave the block
    `LZCE_ASSERT_NOW(a_edge_code, i_clk, i_rst_n, r_out_valid, (r_out_edge == EDGE_ON) || (r_out_edge == EDGE_OFF), "edge value not a valid code")
    // Top row and left column are border pixels
    `LZCE_ASSERT_NOW(a_border, i_clk, i_rst_n, r_out_valid && ((r_out_row == '0) || (r_out_col == '0)), r_out_edge == EDGE_OFF, "edge reported on border pixel")

endmodule

`default_nettype wire

>>> verif/laplacian_zero_crossing_edges_test.sv
// Self-checking testbench of the streaming Laplacian zero-crossing edge detector.
`timescale 1ns / 100ps

module laplacian_zero_crossing_edges_test;
    import lzce_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_ITEMS   = 360;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef enum int {IMG_NOISE, IMG_BINARY, IMG_BLOCKS, IMG_RAMP} t_img_style;

    typedef struct packed {
        logic             op;
        logic [RED_W-1:0] red;
    } t_pixel_beat;

    typedef struct packed {
        logic [RED_W-1:0]     edge_value;
        logic [PIX_ROW_W-1:0] pixel_row;
        logic [PIX_COL_W-1:0] pixel_col;
        logic                 frame_end;
    } t_edge_beat;

    logic                 i_clk;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 pix_valid = 1'b0;
    logic                 pix_op    = OP_PIXEL;
    logic [RED_W-1:0]     pix_red   = '0;
    logic                 out_stall = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic [RED_W-1:0]     o_edge_value;
    logic [PIX_ROW_W-1:0] o_pixel_row;
    logic [PIX_COL_W-1:0] o_pixel_col;
    logic                 o_frame_end;

    // Stimulus and expectation stores
    t_pixel_beat pending_pixels[$];
    t_edge_beat  edge_expect[$];
    bit          in_idle_en  = 1'b0;
    bit          out_idle_en = 1'b0;
    int          fail_count  = 0;

    // Shadow of the detector: registers, line stores and scan position
    logic [CFG_W-1:0]        width_reg  = FRAME_WIDTH_RST;
    logic [CFG_W-1:0]        height_reg = FRAME_HEIGHT_RST;
    logic [THR_W-1:0]        thresh_reg = EDGE_THRESHOLD_RST;
    logic [RED_W-1:0]        red_rows [2][MAX_WIDTH];
    logic signed [LAP_W-1:0] lap_row [MAX_WIDTH];
    int                      scan_row = 0;
    int                      scan_col = 0;

    laplacian_zero_crossing_edges u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_valid      (pix_valid),
        .o_stall      (o_stall),
        .i_op         (pix_op),
        .i_red_value  (pix_red),
        .o_valid      (o_valid),
        .i_stall      (out_stall),
        .o_edge_value (o_edge_value),
        .o_pixel_row  (o_pixel_row),
        .o_pixel_col  (o_pixel_col),
        .o_frame_end  (o_frame_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int clamp_size(input logic [CFG_W-1:0] v, input int hi);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    function automatic bit sign_flip(input int a, input int b);
        return (a < 0 && b > 0) || (a > 0 && b < 0);
    endfunction

    function automatic int red_gap(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Advance the shadow by one pixel beat and queue the edge beat it releases
    function automatic void predict_edge(input logic op, input logic [RED_W-1:0] red);
        int w, h, r_in, c_in, r_out, cur, lap_new, lc, lr, rc, rr, rd;
        logic slot_now, slot_prev, hit;
        t_edge_beat beat;
        w = clamp_size(width_reg, MAX_WIDTH);
        h = clamp_size(height_reg, MAX_HEIGHT);
        r_in = scan_row;
        c_in = scan_col;
        cur = (r_in < h && op == OP_PIXEL) ? int'(red) : 0;
        slot_now = r_in[0];
        slot_prev = ~r_in[0];

        // Laplacian of the pixel one row up
        lap_new = 0;
        if (r_in >= 2 && r_in - 1 <= h - 2 && c_in >= 1 && c_in <= w - 2)
            lap_new = int'(red_rows[slot_now][c_in]) + cur
                      + int'(red_rows[slot_prev][c_in - 1]) + int'(red_rows[slot_prev][c_in + 1])
                      - 4 * int'(red_rows[slot_prev][c_in]);

        // Decide the pixel two rows up against its right and lower neighbors
        if (r_in >= 2) begin
            r_out = r_in - 2;
            hit = 1'b0;
            if (r_out >= 1 && r_out <= h - 2 && c_in >= 1 && c_in <= w - 2) begin
                lc = int'(lap_row[c_in]);
                lr = (c_in + 1 <= w - 2) ? int'(lap_row[c_in + 1]) : 0;
                rc = int'(red_rows[slot_now][c_in]);
                rr = int'(red_rows[slot_now][c_in + 1]);
                rd = int'(red_rows[slot_prev][c_in]);
                hit = (sign_flip(lc, lr) && red_gap(rc, rr) >= int'(thresh_reg)) ||
                      (sign_flip(lc, lap_new) && red_gap(rc, rd) >= int'(thresh_reg));
            end
            beat.edge_value = hit ? EDGE_ON : EDGE_OFF;
            beat.pixel_row  = r_out[PIX_ROW_W-1:0];
            beat.pixel_col  = c_in[PIX_COL_W-1:0];
            beat.frame_end  = (r_out == h - 1 && c_in == w - 1);
            edge_expect.push_back(beat);
        end

        // Update the line stores and step the raster position
        lap_row[c_in] = lap_new[LAP_W-1:0];
        if (r_in < h)
            red_rows[slot_now][c_in] = cur[RED_W-1:0];
        if (scan_col + 1 >= w) begin
            scan_col = 0;
            scan_row = (scan_row + 1 >= h + 2) ? 0 : scan_row + 1;
        end else begin
            scan_col = scan_col + 1;
        end
    endfunction

    // Driver: present queued pixels, hold while stalled, insert idle bursts
    int in_gap = 0;
    always @(posedge i_clk) begin
        t_pixel_beat next_pix;
        if (!rst_n) begin
            pix_valid <= 1'b0;
        end else begin
            if (pix_valid && !o_stall)
                predict_edge(pix_op, pix_red);
            if (!pix_valid || !o_stall) begin
                if (in_gap > 0) begin
                    in_gap = in_gap - 1;
                    pix_valid <= 1'b0;
                end else if (pending_pixels.size() != 0) begin
                    if (in_idle_en && $urandom_range(0, 9) == 0) begin
                        in_gap = $urandom_range(1, 16) - 1;
                        pix_valid <= 1'b0;
                    end else begin
                        next_pix = pending_pixels.pop_front();
                        pix_valid <= 1'b1;
                        pix_op    <= next_pix.op;
                        pix_red   <= next_pix.red;
                    end
                end else begin
                    pix_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each edge beat against the oldest expectation, stall in bursts
    int out_hold = 0;
    always @(posedge i_clk) begin
        t_edge_beat got, want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_valid === 1'b1 && !out_stall) begin
                got = {o_edge_value, o_pixel_row, o_pixel_col, o_frame_end};
                if (edge_expect.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected edge beat: edge %0d row %0d col %0d end %0b",
                                 got.edge_value, got.pixel_row, got.pixel_col, got.frame_end);
                end else begin
                    want = edge_expect.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("edge mismatch: want %0d %0d %0d %0b got %0d %0d %0d %0b",
                                     want.edge_value, want.pixel_row, want.pixel_col,
                                     want.frame_end, got.edge_value, got.pixel_row,
                                     got.pixel_col, got.frame_end);
                    end
                end
            end
            if (out_hold > 0) begin
                out_hold = out_hold - 1;
                out_stall <= 1'b1;
            end else if (out_idle_en && $urandom_range(0, 9) == 0) begin
                out_hold = $urandom_range(1, 16) - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: end the run when no beat moves for too long
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (rst_n) begin
            if ((pix_valid && !o_stall) || (o_valid === 1'b1 && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Write one register at an edge and mirror it in the shadow
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_FRAME_WIDTH:    width_reg  = data;
            CFG_FRAME_HEIGHT:   height_reg = data;
            CFG_EDGE_THRESHOLD: thresh_reg = data[THR_W-1:0];
            default: ;
        endcase
    endtask

    // Wait until every pixel is taken and every edge beat has come back
    task automatic drain();
        while (pending_pixels.size() != 0 || pix_valid || edge_expect.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Queue one frame plus its flush beats; noisy adds pads inside and pixels after
    task automatic queue_frame(input int w, input int h, input t_img_style style,
                               input bit noisy);
        t_pixel_beat pix;
        int level;
        level = $urandom_range(0, 255);
        for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
                case (style)
                    IMG_NOISE:  pix.red = RED_W'($urandom_range(0, 255));
                    IMG_BINARY: pix.red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    IMG_BLOCKS: begin
                        if ($urandom_range(0, 3) == 0)
                            level = $urandom_range(0, 255);
                        pix.red = level[RED_W-1:0];
                    end
                    default:    pix.red = RED_W'(c * 37 + r * 11 + $urandom_range(0, 3));
                endcase
                pix.op = (noisy && $urandom_range(0, 29) == 0) ? OP_PAD : OP_PIXEL;
                pending_pixels.push_back(pix);
            end
        end
        for (int k = 0; k < 2 * w; k++) begin
            pix.op  = (noisy && $urandom_range(0, 3) == 0) ? OP_PIXEL : OP_PAD;
            pix.red = RED_W'($urandom_range(0, 255));
            pending_pixels.push_back(pix);
        end
    endtask

    initial begin
        t_pixel_beat pix;
        int rand_items, w, h;
        logic [CFG_W-1:0] w_data, h_data;
        logic [THR_W-1:0] thr;

        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;

        // Directed: 4x4 checkerboard at full threshold, a pad inside the frame,
        // pixels mixed into the flush rows
        write_reg(CFG_FRAME_WIDTH, 11'd4);
        write_reg(CFG_FRAME_HEIGHT, 11'd4);
        write_reg(CFG_EDGE_THRESHOLD, 11'h7FF);
        write_reg(CFG_UNUSED_INDEX, 11'h5A5);
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                pix.op  = (r == 2 && c == 2) ? OP_PAD : OP_PIXEL;
                pix.red = ((r + c) % 2 == 0) ? 8'hFF : 8'h00;
                pending_pixels.push_back(pix);
            end
        end
        for (int k = 0; k < 8; k++) begin
            pix.op  = k[0] ? OP_PIXEL : OP_PAD;
            pix.red = k[1] ? 8'hFF : 8'h00;
            pending_pixels.push_back(pix);
        end
        drain();

        // Random small frames, sizes below the minimum included
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            w_data = CFG_W'($urandom_range(0, 12));
            h_data = CFG_W'($urandom_range(0, 9));
            case ($urandom_range(0, 4))
                0:       thr = 8'd0;
                1:       thr = 8'd255;
                default: thr = THR_W'($urandom_range(0, 80));
            endcase
            write_reg(CFG_FRAME_WIDTH, w_data);
            write_reg(CFG_FRAME_HEIGHT, h_data);
            write_reg(CFG_EDGE_THRESHOLD, {3'($urandom), thr});
            in_idle_en  = ($urandom_range(0, 3) != 0);
            out_idle_en = ($urandom_range(0, 3) != 0);
            w = clamp_size(w_data, MAX_WIDTH);
            h = clamp_size(h_data, MAX_HEIGHT);
            queue_frame(w, h, t_img_style'($urandom_range(0, 3)), 1'b1);
            rand_items += w * h + 2 * w;
            drain();
        end

        // Narrow frame clamped up to the minimum width, no idling from here on
        write_reg(CFG_FRAME_WIDTH, 11'd2);
        write_reg(CFG_FRAME_HEIGHT, 11'd6);
        write_reg(CFG_EDGE_THRESHOLD, 11'd20);
        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
        queue_frame(MIN_SIZE, 6, IMG_BLOCKS, 1'b1);
        drain();
        repeat (16) @(posedge i_clk);

        if (fail_count == 0 && edge_expect.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
